FILE: rtl/sgm_pkg.sv
// Shared types and constants for the Sobel gradient magnitude block.
`default_nettype none
package sgm_pkg;
  localparam int MaxWidth  = 2048;
  localparam int AddrW     = $clog2(MaxWidth);
  localparam int PosW      = 11;
  localparam int CfgW      = 12;
  localparam int SqW       = 18;
  localparam int RootSteps = SqW / 2;
  localparam int StepW     = $clog2(RootSteps);

  localparam logic CfgWidth  = 1'b0;
  localparam logic CfgHeight = 1'b1;

  typedef struct packed {
    logic load;     // capture input transaction, issue line store read
    logic calc;     // gradients, line store write, window/counter update
    logic square;   // sum of squares, root init
    logic root;     // one square-root step
    logic out_load; // move result into output register
  } cmd_t;

  typedef struct packed {
    logic emit;
    logic out_free;
  } sts_t;
endpackage
`default_nettype wire

FILE: rtl/sgm_ctrl.sv
// Controller state machine sequencing one pixel through the datapath.
`default_nettype none
module sgm_ctrl (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_valid,
  output logic              in_ready,
  input  sgm_pkg::sts_t     sts,
  output sgm_pkg::cmd_t     cmd
);
  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StCalc = 3'd1;
  localparam logic [2:0] StSq   = 3'd2;
  localparam logic [2:0] StRoot = 3'd3;
  localparam logic [2:0] StDone = 3'd4;

  logic [2:0] state_r, state_nxt;
  logic [sgm_pkg::StepW-1:0] step_r, step_nxt;

  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      StIdle: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = StCalc;
        end
      end
      StCalc: begin
        cmd.calc  = 1'b1;
        state_nxt = sts.emit ? StSq : StIdle;
      end
      StSq: begin
        cmd.square = 1'b1;
        step_nxt   = '0;
        state_nxt  = StRoot;
      end
      StRoot: begin
        cmd.root = 1'b1;
        step_nxt = step_r + 1'b1;
        if (step_r == sgm_pkg::StepW'(sgm_pkg::RootSteps - 1)) state_nxt = StDone;
      end
      StDone: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = StIdle;
        end
      end
      default: state_nxt = StIdle;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= StIdle;
      step_r  <= '0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
    end
  end
endmodule
`default_nettype wire

FILE: rtl/sgm_datapath.sv
// Datapath: line stores, window, counters, gradients, square root, output register.
`default_nettype none
module sgm_datapath (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  sgm_pkg::cmd_t                  cmd,
  output sgm_pkg::sts_t                  sts,
  input  wire logic                      cfg_we,
  input  wire logic                      cfg_index,
  input  wire logic [sgm_pkg::CfgW-1:0]  cfg_data,
  input  wire logic [7:0]                in_red,
  input  wire logic [7:0]                in_green,
  input  wire logic [7:0]                in_blue,
  input  wire logic                      in_frame_start,
  output logic                           out_valid,
  input  wire logic                      out_ready,
  output logic [7:0]                     out_mag_red,
  output logic [7:0]                     out_mag_green,
  output logic [7:0]                     out_mag_blue,
  output logic signed [8:0]              out_grad_x_red,
  output logic signed [8:0]              out_grad_x_green,
  output logic signed [8:0]              out_grad_x_blue,
  output logic signed [8:0]              out_grad_y_red,
  output logic signed [8:0]              out_grad_y_green,
  output logic signed [8:0]              out_grad_y_blue,
  output logic [sgm_pkg::PosW-1:0]       out_row,
  output logic [sgm_pkg::PosW-1:0]       out_col,
  output logic                           out_last_of_frame
);
  localparam int AW = sgm_pkg::AddrW;
  localparam int PW = sgm_pkg::PosW;
  localparam int CW = sgm_pkg::CfgW;
  localparam int QW = sgm_pkg::SqW;

  logic [CW-1:0] width_r, height_r;
  logic [PW-1:0] wm1, hm1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= CW'(640);
      height_r <= CW'(480);
    end else if (cfg_we) begin
      if (cfg_index == sgm_pkg::CfgWidth) width_r <= cfg_data;
      else height_r <= cfg_data;
    end
  end

  // effective last column / row, sizes clamped to 3..2048
  always_comb begin
    if (width_r < CW'(3)) wm1 = PW'(2);
    else if (width_r > CW'(sgm_pkg::MaxWidth)) wm1 = PW'(sgm_pkg::MaxWidth - 1);
    else wm1 = PW'(width_r - 1'b1);
    if (height_r < CW'(3)) hm1 = PW'(2);
    else if (height_r > CW'(2048)) hm1 = PW'(2047);
    else hm1 = PW'(height_r - 1'b1);
  end

  // position counters
  logic [PW-1:0] col_r, row_r, col_eff, row_eff;
  logic [PW-1:0] col_ld_r, row_ld_r;
  logic [2:0][7:0] cur_r;

  assign col_eff = in_frame_start ? '0 : col_r;
  assign row_eff = in_frame_start ? '0 : row_r;

  // line stores
  logic [23:0] older_mem [sgm_pkg::MaxWidth];
  logic [23:0] newer_mem [sgm_pkg::MaxWidth];
  logic [23:0] top_r, mid_r;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      top_r <= older_mem[col_eff[AW-1:0]];
      mid_r <= newer_mem[col_eff[AW-1:0]];
    end
    if (cmd.calc) begin
      older_mem[col_ld_r[AW-1:0]] <= mid_r;
      newer_mem[col_ld_r[AW-1:0]] <= cur_r;
    end
  end

  logic [5:0][23:0] win_r;

  // gradients
  logic [2:0] [7:0] pl0, pm0, pr0, pl1, pr1, pl2, pm2, pr2;
  logic signed [10:0] sx [3];
  logic [9:0] vy0 [3], vy2 [3];
  logic signed [8:0] gx_c [3], gy_c [3];
  logic emit;

  assign pl0 = win_r[0]; assign pm0 = win_r[1]; assign pr0 = top_r;
  assign pl1 = win_r[2];                        assign pr1 = mid_r;
  assign pl2 = win_r[4]; assign pm2 = win_r[5]; assign pr2 = cur_r;

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      sx[c] = $signed({3'b000, pr0[c]}) - $signed({3'b000, pl0[c]})
            + (($signed({3'b000, pr1[c]}) - $signed({3'b000, pl1[c]})) <<< 1)
            + $signed({3'b000, pr2[c]}) - $signed({3'b000, pl2[c]});
      gx_c[c] = sx[c][10] ? 9'((sx[c] + 11'sd3) >>> 2) : 9'(sx[c] >>> 2);
      vy0[c] = ({2'b00, pl0[c]} + {1'b0, pm0[c], 1'b0} + {2'b00, pr0[c]}) >> 2;
      vy2[c] = ({2'b00, pl2[c]} + {1'b0, pm2[c], 1'b0} + {2'b00, pr2[c]}) >> 2;
      gy_c[c] = $signed({1'b0, vy0[c][7:0]}) - $signed({1'b0, vy2[c][7:0]});
    end
  end

  assign emit = (row_ld_r >= PW'(2)) && (col_ld_r >= PW'(2)) &&
                (row_ld_r <= hm1) && (col_ld_r <= wm1);
  assign sts.emit = emit;

  logic signed [8:0] gx_r [3], gy_r [3];
  logic [PW-1:0] orow_r, ocol_r;
  logic last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
      win_r <= '0;
    end else begin
      if (cmd.load) begin
        cur_r    <= {in_blue, in_green, in_red};
        col_ld_r <= col_eff;
        row_ld_r <= row_eff;
      end
      if (cmd.calc) begin
        win_r <= {cur_r, win_r[5], mid_r, win_r[3], top_r, win_r[1]};
        if (col_ld_r >= wm1) begin
          col_r <= '0;
          row_r <= (row_ld_r >= hm1) ? '0 : row_ld_r + 1'b1;
        end else begin
          col_r <= col_ld_r + 1'b1;
          row_r <= row_ld_r;
        end
        for (int c = 0; c < 3; c++) begin
          gx_r[c] <= gx_c[c];
          gy_r[c] <= gy_c[c];
        end
        orow_r <= row_ld_r - 1'b1;
        ocol_r <= col_ld_r - 1'b1;
        last_r <= (row_ld_r == hm1) && (col_ld_r == wm1);
      end
    end
  end

  // sum of squares and bit-pair square root, three channels side by side
  logic [QW-1:0] rem_r [3], root_r [3], bit_r;
  logic signed [QW-1:0] gxe [3], gye [3], px [3], py [3];
  logic [QW-1:0] trial [3];

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      gxe[c]   = QW'(gx_r[c]);
      gye[c]   = QW'(gy_r[c]);
      px[c]    = gxe[c] * gxe[c];
      py[c]    = gye[c] * gye[c];
      trial[c] = root_r[c] + bit_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.square) begin
      bit_r <= QW'(1) << (QW - 2);
      for (int c = 0; c < 3; c++) begin
        rem_r[c]  <= $unsigned(px[c]) + $unsigned(py[c]);
        root_r[c] <= '0;
      end
    end else if (cmd.root) begin
      bit_r <= bit_r >> 2;
      for (int c = 0; c < 3; c++) begin
        if (rem_r[c] >= trial[c]) begin
          rem_r[c]  <= rem_r[c] - trial[c];
          root_r[c] <= (root_r[c] >> 1) + bit_r;
        end else begin
          root_r[c] <= root_r[c] >> 1;
        end
      end
    end
  end

  // output register
  logic out_valid_r;
  logic [7:0] mag [3];

  always_comb begin
    for (int c = 0; c < 3; c++)
      mag[c] = (root_r[c] > QW'(255)) ? 8'hFF : root_r[c][7:0];
  end

  assign sts.out_free = !out_valid_r || out_ready;
  assign out_valid    = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_mag_red       <= mag[0];
      out_mag_green     <= mag[1];
      out_mag_blue      <= mag[2];
      out_grad_x_red    <= gx_r[0];
      out_grad_x_green  <= gx_r[1];
      out_grad_x_blue   <= gx_r[2];
      out_grad_y_red    <= gy_r[0];
      out_grad_y_green  <= gy_r[1];
      out_grad_y_blue   <= gy_r[2];
      out_row           <= orow_r;
      out_col           <= ocol_r;
      out_last_of_frame <= last_r;
    end
  end
endmodule
`default_nettype wire

FILE: rtl/sobel_gradient_magnitude_top.sv
// Top level of the Sobel 3x3 gradient magnitude block.
// RGB pixels enter in raster order, one transaction per pixel; each interior
// pixel yields one result transaction (gradients, magnitude, position), border
// pixels yield none. A pixel is accepted with a line store read, then its
// gradients and window update are computed; one with a result goes on to the
// squares, the bit-pair square root steps (three channels side by side) and,
// once the output register is free, the output register load. The next pixel
// is accepted only after the current one has left any result in the output
// register, so a result may wait there while the following pixel is worked.
// frame_width and frame_height are written through cfg_we/cfg_index/cfg_data;
// the user must write them only while the block is idle; the block does not
// enforce this. They are clamped to 3..2048. frame_start forces the pixel to
// row 0, column 0; after the last pixel the counters wrap on their own.
// The line stores need no clearing after reset.
`default_nettype none
module sobel_gradient_magnitude_top (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      cfg_we,
  input  wire logic                      cfg_index,
  input  wire logic [sgm_pkg::CfgW-1:0]  cfg_data,
  input  wire logic                      in_valid,
  output logic                           in_ready,
  input  wire logic [7:0]                in_red,
  input  wire logic [7:0]                in_green,
  input  wire logic [7:0]                in_blue,
  input  wire logic                      in_frame_start,
  output logic                           out_valid,
  input  wire logic                      out_ready,
  output logic [7:0]                     out_mag_red,
  output logic [7:0]                     out_mag_green,
  output logic [7:0]                     out_mag_blue,
  output logic signed [8:0]              out_grad_x_red,
  output logic signed [8:0]              out_grad_x_green,
  output logic signed [8:0]              out_grad_x_blue,
  output logic signed [8:0]              out_grad_y_red,
  output logic signed [8:0]              out_grad_y_green,
  output logic signed [8:0]              out_grad_y_blue,
  output logic [sgm_pkg::PosW-1:0]       out_row,
  output logic [sgm_pkg::PosW-1:0]       out_col,
  output logic                           out_last_of_frame
);
  sgm_pkg::cmd_t cmd;
  sgm_pkg::sts_t sts;

  sgm_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  sgm_datapath u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .sts               (sts),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .in_red            (in_red),
    .in_green          (in_green),
    .in_blue           (in_blue),
    .in_frame_start    (in_frame_start),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_mag_red       (out_mag_red),
    .out_mag_green     (out_mag_green),
    .out_mag_blue      (out_mag_blue),
    .out_grad_x_red    (out_grad_x_red),
    .out_grad_x_green  (out_grad_x_green),
    .out_grad_x_blue   (out_grad_x_blue),
    .out_grad_y_red    (out_grad_y_red),
    .out_grad_y_green  (out_grad_y_green),
    .out_grad_y_blue   (out_grad_y_blue),
    .out_row           (out_row),
    .out_col           (out_col),
    .out_last_of_frame (out_last_of_frame)
  );
endmodule
`default_nettype wire

FILE: test/tb.sv
// Testbench for the Sobel gradient magnitude block: stream of pixels with a running predictor.
module tb;
  // Pixel transaction as the driver sends it.
  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       frame_start;
  } pixel_t;

  // One result transaction as the block should produce it.
  typedef struct packed {
    logic [7:0]  mag_r, mag_g, mag_b;
    logic [8:0]  gx_r, gx_g, gx_b;
    logic [8:0]  gy_r, gy_g, gy_b;
    logic [10:0] row, col;
    logic        last;
  } grad_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic cfg_index = 1'b0;
  logic [sgm_pkg::CfgW-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [7:0] in_red = '0, in_green = '0, in_blue = '0;
  logic in_frame_start = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [7:0] out_mag_red, out_mag_green, out_mag_blue;
  logic signed [8:0] out_grad_x_red, out_grad_x_green, out_grad_x_blue;
  logic signed [8:0] out_grad_y_red, out_grad_y_green, out_grad_y_blue;
  logic [10:0] out_row, out_col;
  logic out_last_of_frame;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  sobel_gradient_magnitude_top i_dut (
    .clk, .rst_n, .cfg_we, .cfg_index, .cfg_data,
    .in_valid, .in_ready, .in_red, .in_green, .in_blue, .in_frame_start,
    .out_valid, .out_ready, .out_mag_red, .out_mag_green, .out_mag_blue,
    .out_grad_x_red, .out_grad_x_green, .out_grad_x_blue,
    .out_grad_y_red, .out_grad_y_green, .out_grad_y_blue,
    .out_row, .out_col, .out_last_of_frame
  );

  // ---------------- predictor state ----------------
  logic [11:0] model_width, model_height;
  logic [23:0] line_old [sgm_pkg::MaxWidth];
  logic [23:0] line_new [sgm_pkg::MaxWidth];
  logic [23:0] win [6];
  int unsigned col_pos, row_pos;

  pixel_t pending_pixels[$];
  grad_t  expected_grads[$];
  int errors = 0;
  int n_sent = 0, n_got = 0;
  int settings_seen = 0;

  function automatic int unsigned int_sqrt(int unsigned v);
    int unsigned root = 0;
    int unsigned b = 1 << 30;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= root + b) begin
        v -= root + b;
        root = (root >> 1) + b;
      end else begin
        root >>= 1;
      end
      b >>= 2;
    end
    return root;
  endfunction

  function automatic int ch(logic [23:0] px, int c);
    return int'(px[8*c +: 8]);
  endfunction

  // Advance the predictor by one accepted pixel; queue a result for interior pixels.
  task automatic predict_gradient(pixel_t px);
    int unsigned w, h, m;
    logic [23:0] cur, top, mid;
    logic [23:0] p [3][3];
    int hx0, hx1, hx2, gx, vy0, vy2, gy;
    grad_t g;
    w = model_width < 3 ? 3 :
        (model_width > sgm_pkg::MaxWidth ? sgm_pkg::MaxWidth : model_width);
    h = model_height < 3 ? 3 : (model_height > 2048 ? 2048 : model_height);
    cur = {px.blue, px.green, px.red};
    top = '0;
    mid = '0;
    if (px.frame_start) begin
      col_pos = 0;
      row_pos = 0;
    end
    if (col_pos < sgm_pkg::MaxWidth) begin
      top = line_old[col_pos];
      mid = line_new[col_pos];
      line_old[col_pos] = mid;
      line_new[col_pos] = cur;
    end
    p[0][0] = win[0]; p[0][1] = win[1]; p[0][2] = top;
    p[1][0] = win[2]; p[1][1] = win[3]; p[1][2] = mid;
    p[2][0] = win[4]; p[2][1] = win[5]; p[2][2] = cur;
    if (row_pos >= 2 && col_pos >= 2 && row_pos < h && col_pos < w) begin
      g = '0;
      for (int c = 0; c < 3; c++) begin
        hx0 = ch(p[0][2], c) - ch(p[0][0], c);
        hx1 = ch(p[1][2], c) - ch(p[1][0], c);
        hx2 = ch(p[2][2], c) - ch(p[2][0], c);
        gx = (hx0 + 2 * hx1 + hx2) / 4;  // SV division truncates toward zero
        vy0 = (ch(p[0][0], c) + 2 * ch(p[0][1], c) + ch(p[0][2], c)) / 4;
        vy2 = (ch(p[2][0], c) + 2 * ch(p[2][1], c) + ch(p[2][2], c)) / 4;
        gy = vy0 - vy2;
        m = int_sqrt(gx * gx + gy * gy);
        if (m > 255) m = 255;
        case (c)
          0: begin g.mag_r = m[7:0]; g.gx_r = gx[8:0]; g.gy_r = gy[8:0]; end
          1: begin g.mag_g = m[7:0]; g.gx_g = gx[8:0]; g.gy_g = gy[8:0]; end
          default: begin g.mag_b = m[7:0]; g.gx_b = gx[8:0]; g.gy_b = gy[8:0]; end
        endcase
      end
      g.row = 11'(row_pos - 1);
      g.col = 11'(col_pos - 1);
      g.last = (row_pos == h - 1) && (col_pos == w - 1);
      expected_grads = {expected_grads, g};
    end
    win[0] = p[0][1]; win[1] = top;
    win[2] = p[1][1]; win[3] = mid;
    win[4] = p[2][1]; win[5] = cur;
    if (col_pos >= w - 1) begin
      col_pos = 0;
      row_pos = (row_pos >= h - 1) ? 0 : row_pos + 1;
    end else begin
      col_pos++;
    end
  endtask

  // ---------------- driver ----------------
  int send_gap = 0;
  logic hold_sender = 1'b0;  // set by the stimulus to pause sending
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) begin
        predict_gradient(pending_pixels.pop_front());
        n_sent++;
        send_gap = $urandom_range(0, 3) == 0 ? $urandom_range(0, 14) : 0;
      end
      if ((!in_valid || in_ready) ) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (pending_pixels.size() > 0 && !hold_sender) begin
          in_valid <= 1'b1;
          {in_red, in_green, in_blue, in_frame_start} <= pending_pixels[0];
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------- monitor and receiver stalls ----------------
  int recv_gap = 0;
  int long_hold = 0;  // cycles left of a long receiver hold-off
  always @(posedge clk) begin
    grad_t got, exp_g;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        got = '{out_mag_red, out_mag_green, out_mag_blue,
                out_grad_x_red, out_grad_x_green, out_grad_x_blue,
                out_grad_y_red, out_grad_y_green, out_grad_y_blue,
                out_row, out_col, out_last_of_frame};
        n_got++;
        if (expected_grads.size() == 0) begin
          errors++;
          $display("%0t: unexpected result, expected none, actual %p", $time, got);
        end else begin
          exp_g = expected_grads.pop_front();
          if (got.mag_r !== exp_g.mag_r || got.mag_g !== exp_g.mag_g ||
              got.mag_b !== exp_g.mag_b || got.gx_r !== exp_g.gx_r ||
              got.gx_g !== exp_g.gx_g || got.gx_b !== exp_g.gx_b ||
              got.gy_r !== exp_g.gy_r || got.gy_g !== exp_g.gy_g ||
              got.gy_b !== exp_g.gy_b || got.row !== exp_g.row ||
              got.col !== exp_g.col || got.last !== exp_g.last) begin
            errors++;
            $display("%0t: mismatch, expected %p, actual %p", $time, exp_g, got);
          end
        end
        recv_gap = $urandom_range(0, 3) == 0 ? $urandom_range(0, 14) : 0;
      end
      if (long_hold > 0) begin
        long_hold--;
        out_ready <= 1'b0;
      end else if (recv_gap > 0) begin
        recv_gap--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // ---------------- watchdog ----------------
  int stuck = 0;
  always @(posedge clk) begin
    if (rst_n) begin
      stuck = ((in_valid && in_ready) || (out_valid && out_ready)) ? 0 : stuck + 1;
      if (stuck >= 20000) begin
        $display("tb: done, errors");
        $finish;
      end
    end
  end

  // ---------------- stimulus ----------------
  function automatic pixel_t rand_pixel(logic fs);
    pixel_t p;
    p.red = 8'($urandom);
    p.green = 8'($urandom);
    p.blue = 8'($urandom);
    p.frame_start = fs;
    return p;
  endfunction

  task automatic wait_drained();
    while (pending_pixels.size() > 0 || in_valid || expected_grads.size() > 0)
      @(posedge clk);
    repeat (20) @(posedge clk);  // a border pixel may still be in flight
  endtask

  // Write both size registers while idle; predictor follows the write.
  task automatic set_frame(logic [11:0] w, logic [11:0] h);
    @(posedge clk);
    cfg_we <= 1'b1; cfg_index <= sgm_pkg::CfgWidth; cfg_data <= w;
    @(posedge clk);
    model_width = w;
    cfg_index <= sgm_pkg::CfgHeight; cfg_data <= h;
    @(posedge clk);
    model_height = h;
    cfg_we <= 1'b0;
    settings_seen++;
  endtask

  // Queue whole random-pixel frames; frame_start opens the first frame, later ones at random.
  task automatic queue_frames(int w, int h, int n);
    for (int f = 0; f < n; f++)
      for (int i = 0; i < w * h; i++)
        pending_pixels = {pending_pixels,
                          rand_pixel(i == 0 && ($urandom_range(0, 3) != 0 || f == 0))};
  endtask

  initial begin
    pixel_t p;
    int w, h;
    model_width = 640;
    model_height = 480;
    col_pos = 0;
    row_pos = 0;
    for (int i = 0; i < 6; i++) win[i] = '0;
    for (int i = 0; i < sgm_pkg::MaxWidth; i++) begin
      line_old[i] = '0;
      line_new[i] = '0;
    end
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: smallest frame, with extremes: all-zero/all-max patterns drive the green y and
    // blue x gradients to their positive limit and those magnitudes to 255; red stays at zero.
    set_frame(12'd3, 12'd3);
    for (int i = 0; i < 9; i++) begin
      p.red = (i % 2) ? 8'hFF : 8'h00;
      p.green = (i < 3) ? 8'hFF : 8'h00;
      p.blue = (i % 3 == 2) ? 8'hFF : 8'h00;
      p.frame_start = (i == 0);
      pending_pixels = {pending_pixels, p};
    end
    // Second frame without frame_start (counters wrap), opposite extremes.
    for (int i = 0; i < 9; i++) begin
      p.red = (i % 3 == 0) ? 8'hFF : 8'h00;
      p.green = (i >= 6) ? 8'hFF : 8'h00;
      p.blue = 8'h80;
      p.frame_start = 1'b0;
      pending_pixels = {pending_pixels, p};
    end
    // Frame cut short mid-row by the frame_start of the next frame.
    for (int i = 0; i < 4; i++) pending_pixels = {pending_pixels, rand_pixel(i == 0)};
    wait_drained();

    // Out-of-range sizes clamp to three.
    set_frame(12'd0, 12'd1);
    queue_frames(3, 3, 1);
    wait_drained();

    // Long receiver hold-off while pixels keep coming: block must stall its input.
    set_frame(12'd6, 12'd5);
    queue_frames(6, 5, 2);
    long_hold = 300;
    wait_drained();

    // Sender pauses until all results are back, then resumes.
    hold_sender = 1'b1;
    queue_frames(6, 5, 1);
    hold_sender = 1'b0;
    while (n_sent < 120) @(posedge clk);
    hold_sender = 1'b1;
    while (expected_grads.size() > 0) @(posedge clk);
    hold_sender = 1'b0;
    wait_drained();

    // Size change mid-frame: shrink the width while counters sit past it.
    set_frame(12'd10, 12'd6);
    for (int i = 0; i < 27; i++) pending_pixels = {pending_pixels, rand_pixel(i == 0)};
    wait_drained();
    set_frame(12'd4, 12'd4);
    for (int i = 0; i < 40; i++) pending_pixels = {pending_pixels, rand_pixel(1'b0)};
    wait_drained();

    // Random frames of small sizes.
    while (n_sent < 1000) begin
      w = $urandom_range(3, 12);
      h = $urandom_range(3, 8);
      set_frame(12'(w), 12'(h));
      queue_frames(w, h, $urandom_range(1, 2));
      // Noise: occasional stray frame_start in the middle.
      if ($urandom_range(0, 4) == 0)
        pending_pixels[$urandom_range(1, pending_pixels.size() - 1)].frame_start = 1'b1;
      wait_drained();
    end
    // Oversize height clamps to 2048: a few rows, the frame does not end here.
    set_frame(12'd6, 12'd4095);
    for (int i = 0; i < 36; i++) pending_pixels = {pending_pixels, rand_pixel(i == 0)};
    wait_drained();

    $display("tb: %0d pixels sent, %0d results checked over %0d frame settings",
             n_sent, n_got, settings_seen);
    $display("tb: covered clamped sizes, mid-frame resizes, stray frame starts and long stalls");
    if (errors == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end
endmodule

FILE: filelist.f
rtl/sgm_pkg.sv
rtl/sgm_ctrl.sv
rtl/sgm_datapath.sv
rtl/sobel_gradient_magnitude_top.sv
test/tb.sv
